// File: hw/rtl/rpce_pkg.sv
package rpce_pkg;

   // table geometry
   localparam int MAX_POINTS  = 512;
   localparam int PTR_W       = $clog2(MAX_POINTS);
   localparam int CNT_W       = PTR_W + 1;
   localparam int CSR_W       = 10;

   // fixed point
   localparam int X_FRAC_BITS = 32;
   localparam int W_FRAC      = 30;
   localparam int WRK_W       = 36;
   localparam int MUL_W       = 34;
   localparam int PRD_W       = 2 * MUL_W;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [32:0] CDF_ONE = 33'h1_0000_0000;

   typedef struct packed {
      logic               func;
      logic [8:0]         entry_index;
      logic signed [63:0] x_value;
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic [31:0]        cum_prob;
      logic [31:0]        interval_prob;
   } req_type;

   typedef struct packed {
      logic [63:0] pdf_value;
      logic [32:0] cdf_value;
   } rsp_type;

   typedef struct packed {
      logic signed [63:0] grid_x;
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic [31:0]        cum;
      logic [31:0]        mass;
   } entry_type;

endpackage

// File: hw/rtl/rita_pdf_cdf_evaluator_core.sv
// A load request is written in its accept cycle and leaves busy low. A query
// above the grid is answered from ST_RD_LAST, one below it from ST_RD_FIRST.
// Inside it the core runs the binary search, then zero to four serial divisions
// and, when the linear term is nonzero, the square root. One query at a time;
// the next request is taken in the result cycle. Reset (synchronous, active
// high) clears control, points to 2.
module rita_pdf_cdf_evaluator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  rpce_pkg::req_type              req_item,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rpce_pkg::CSR_W-1:0]     csr_data,
   output logic                           rsp_valid,
   output rpce_pkg::rsp_type              rsp_item
);

   // Sequencer states. The table sits in one memory with a write port and a
   // registered read port; every step that needs an entry issues the address in the
   // state before it. A 34x34 multiplier with a registered product and a
   // one-bit-per-cycle 128/64 divider are shared by all steps that need them.
   typedef enum logic [30:0] {
      ST_IDLE     = 31'h0000_0001,
      ST_RD_LAST  = 31'h0000_0002,
      ST_RD_FIRST = 31'h0000_0004,
      ST_SRCH_RD  = 31'h0000_0008,
      ST_SRCH_CMP = 31'h0000_0010,
      ST_RD_I     = 31'h0000_0020,
      ST_RD_I1    = 31'h0000_0040,
      ST_TAU_PREP = 31'h0000_0080,
      ST_TAU_FIN  = 31'h0000_0100,
      ST_CON_A    = 31'h0000_0200,
      ST_CON_B    = 31'h0000_0400,
      ST_CON_C    = 31'h0000_0800,
      ST_ETA_SEL  = 31'h0000_1000,
      ST_SQ_B     = 31'h0000_2000,
      ST_SQ_C     = 31'h0000_4000,
      ST_SQRT     = 31'h0000_8000,
      ST_ROOT_DEN = 31'h0001_0000,
      ST_ETA_FIN  = 31'h0002_0000,
      ST_EV_A     = 31'h0004_0000,
      ST_EV_B     = 31'h0008_0000,
      ST_EV_C     = 31'h0010_0000,
      ST_EV_D     = 31'h0020_0000,
      ST_EV_E     = 31'h0040_0000,
      ST_EV_F     = 31'h0080_0000,
      ST_EV_G     = 31'h0100_0000,
      ST_EV_H     = 31'h0200_0000,
      ST_EV_I     = 31'h0400_0000,
      ST_EV_J     = 31'h0800_0000,
      ST_PDF_T    = 31'h1000_0000,
      ST_PDF_FIN  = 31'h2000_0000,
      ST_DIV      = 31'h4000_0000
   } state_type;

   localparam logic signed [rpce_pkg::WRK_W-1:0] W_ONE = 36'sh0_4000_0000;
   localparam logic [30:0] TAU_ONE = 31'h4000_0000;

   // magnitude of a working value, narrowed to the multiplier width
   function automatic logic [rpce_pkg::MUL_W-1:0] mag_of(
      input logic signed [rpce_pkg::WRK_W-1:0] v);
      logic [rpce_pkg::WRK_W-1:0] t;
      t = v[rpce_pkg::WRK_W-1] ? rpce_pkg::WRK_W'(-v) : rpce_pkg::WRK_W'(v);
      return t[rpce_pkg::MUL_W-1:0];
   endfunction

   // reapply the sign to a truncated magnitude
   function automatic logic signed [rpce_pkg::WRK_W-1:0] signed_of(
      input logic neg, input logic [rpce_pkg::WRK_W-1:0] m);
      return neg ? -$signed(m) : $signed(m);
   endfunction

   // table memory
   rpce_pkg::entry_type mem [0:rpce_pkg::MAX_POINTS-1];
   rpce_pkg::entry_type rdata_ff;
   rpce_pkg::entry_type wr_data;
   logic                         wr_en;
   logic [rpce_pkg::PTR_W-1:0]   wr_addr;
   logic [rpce_pkg::PTR_W-1:0]   rd_addr;

   // control
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [rpce_pkg::CSR_W-1:0] pts_ff, pts_in;
   logic [rpce_pkg::CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rpce_pkg::rsp_type          rsp_ff, rsp_in;

   // datapath
   logic signed [63:0] x_ff, x_in, g0_ff, g0_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in;
   logic [31:0]        cum_ff, cum_in, mass_ff, mass_in;
   logic [63:0]        width_ff, width_in;
   logic [30:0]        tau_ff, tau_in, eta_ff, eta_in, ee_ff, ee_in;
   logic signed [rpce_pkg::WRK_W-1:0] con1_ff, con1_in, con2_ff, con2_in;
   logic signed [rpce_pkg::WRK_W-1:0] u_ff, u_in, v_ff, v_in;
   logic signed [rpce_pkg::WRK_W-1:0] w1_ff, w1_in, w2_ff, w2_in;
   logic [35:0]        v2_ff, v2_in, dn_ff, dn_in;
   logic [63:0]        plo_ff, plo_in;
   logic [32:0]        cdf_ff, cdf_in;
   logic [63:0]        d_ff, d_in;
   logic [33:0]        rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic [63:0]        div_hi_ff, div_hi_in, div_lo_ff, div_lo_in;
   logic [63:0]        div_c_ff, div_c_in, div_q_ff, div_q_in;

   // shared multiplier
   logic [rpce_pkg::MUL_W-1:0] mul_x, mul_y;
   logic [rpce_pkg::PRD_W-1:0] prod_ff, prod_in;
   logic [rpce_pkg::WRK_W-1:0] prod_hi;   // product >> W_FRAC

   assign prod_in   = rpce_pkg::PRD_W'(mul_x) * rpce_pkg::PRD_W'(mul_y);
   assign prod_hi   = prod_ff[rpce_pkg::W_FRAC+rpce_pkg::WRK_W-1:rpce_pkg::W_FRAC];
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = ~busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      logic [rpce_pkg::CNT_W-1:0] np;
      logic [rpce_pkg::CNT_W:0]   mid_sum;
      logic [rpce_pkg::CNT_W-1:0] lo_n, hi_n;
      logic signed [rpce_pkg::WRK_W-1:0] a_w, b_w, den, root2;
      logic [63:0]  num, s;
      logic [127:0] wide;
      logic [35:0]  rem_n, trial;
      logic [33:0]  cdf_sum;
      logic         out_go, eta_go, div_go, dn_neg;
      logic [63:0]  out_pdf;
      logic [32:0]  out_cdf;
      logic [31:0]  eta_num;
      logic signed [rpce_pkg::WRK_W-1:0] eta_den;
      logic [63:0]  dv_hi, dv_lo, dv_c;
      state_type    dv_ret;
      logic         qbit;
      logic [63:0]  sh;

      state_in = state_ff;   ret_in = ret_ff;   pts_in = pts_ff;
      lo_in = lo_ff;   hi_in = hi_ff;   mid_in = mid_ff;   cnt_in = cnt_ff;
      rsp_valid_in = 1'b0;   rsp_in = rsp_ff;
      x_in = x_ff;   g0_in = g0_ff;   a_in = a_ff;   b_in = b_ff;
      cum_in = cum_ff;   mass_in = mass_ff;   width_in = width_ff;
      tau_in = tau_ff;   eta_in = eta_ff;   ee_in = ee_ff;
      con1_in = con1_ff;   con2_in = con2_ff;   u_in = u_ff;   v_in = v_ff;
      w1_in = w1_ff;   w2_in = w2_ff;   v2_in = v2_ff;   dn_in = dn_ff;
      plo_in = plo_ff;   cdf_in = cdf_ff;   d_in = d_ff;
      rem_in = rem_ff;   root_in = root_ff;
      div_hi_in = div_hi_ff;   div_lo_in = div_lo_ff;
      div_c_in = div_c_ff;   div_q_in = div_q_ff;
      mul_x = '0;   mul_y = '0;
      den = '0;   root2 = '0;   num = '0;   s = '0;   wide = '0;
      rem_n = '0;   trial = '0;   cdf_sum = '0;   dn_neg = 1'b0;
      qbit = 1'b0;   sh = '0;
      wr_en = 1'b0;   wr_addr = req_item.entry_index;
      wr_data.grid_x = req_item.x_value;
      wr_data.coef_a = req_item.coef_a;
      wr_data.coef_b = req_item.coef_b;
      wr_data.cum    = req_item.cum_prob;
      wr_data.mass   = req_item.interval_prob;
      rd_addr = '0;
      out_go = 1'b0;   out_pdf = '0;   out_cdf = '0;
      eta_go = 1'b0;   eta_num = '0;   eta_den = '0;
      div_go = 1'b0;   dv_hi = '0;   dv_lo = '0;   dv_c = '0;   dv_ret = ST_IDLE;
      a_w = rpce_pkg::WRK_W'(a_ff);
      b_w = rpce_pkg::WRK_W'(b_ff);

      // points_in_use clamped to 2..MAX_POINTS
      if (pts_ff < rpce_pkg::CSR_W'(2)) begin
         np = rpce_pkg::CNT_W'(2);
      end else if (32'(pts_ff) > 32'(rpce_pkg::MAX_POINTS)) begin
         np = rpce_pkg::CNT_W'(rpce_pkg::MAX_POINTS);
      end else begin
         np = rpce_pkg::CNT_W'(pts_ff);
      end

      if (csr_valid && csr_ready) begin
         pts_in = csr_data;
      end

      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      lo_n = lo_ff;
      hi_n = hi_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_item.func == rpce_pkg::FUNC_LOAD) begin
                  wr_en = 1'b1;
               end else begin
                  x_in     = req_item.x_value;
                  hi_in    = np;
                  rd_addr  = rpce_pkg::PTR_W'(np - rpce_pkg::CNT_W'(1));
                  state_in = ST_RD_LAST;
               end
            end
         end
         ST_RD_LAST: begin
            rd_addr = '0;
            if ($signed(x_ff) > $signed(rdata_ff.grid_x)) begin
               out_go  = 1'b1;
               out_cdf = rpce_pkg::CDF_ONE;
            end else begin
               state_in = ST_RD_FIRST;
            end
         end
         ST_RD_FIRST: begin
            if ($signed(x_ff) < $signed(rdata_ff.grid_x)) begin
               out_go = 1'b1;
            end else begin
               lo_in    = rpce_pkg::CNT_W'(1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            mid_in   = mid_sum[rpce_pkg::CNT_W:1];
            rd_addr  = rpce_pkg::PTR_W'(mid_sum[rpce_pkg::CNT_W:1] - rpce_pkg::CNT_W'(1));
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if ($signed(x_ff) > $signed(rdata_ff.grid_x)) begin
               lo_n = mid_ff;
            end else begin
               hi_n = mid_ff;
            end
            lo_in = lo_n;
            hi_in = hi_n;
            if ((hi_n - lo_n) > rpce_pkg::CNT_W'(1)) begin
               state_in = ST_SRCH_RD;
            end else begin
               state_in = ST_RD_I;
            end
         end
         ST_RD_I: begin
            rd_addr  = rpce_pkg::PTR_W'(lo_ff - rpce_pkg::CNT_W'(1));
            state_in = ST_RD_I1;
         end
         ST_RD_I1: begin
            g0_in    = rdata_ff.grid_x;
            a_in     = rdata_ff.coef_a;
            b_in     = rdata_ff.coef_b;
            cum_in   = rdata_ff.cum;
            mass_in  = rdata_ff.mass;
            rd_addr  = rpce_pkg::PTR_W'(lo_ff);
            state_in = ST_TAU_PREP;
         end
         ST_TAU_PREP: begin
            width_in = rdata_ff.grid_x - g0_ff;
            num      = x_ff - g0_ff;
            if ($signed(rdata_ff.grid_x) <= $signed(g0_ff)) begin
               // empty or reversed interval
               out_go  = 1'b1;
               out_cdf = {1'b0, cum_ff};
            end else if ($signed(x_ff) <= $signed(g0_ff)) begin
               tau_in   = '0;
               state_in = ST_CON_A;
            end else if (num >= width_in) begin
               tau_in   = TAU_ONE;
               state_in = ST_CON_A;
            end else begin
               wide   = 128'(num) << rpce_pkg::W_FRAC;
               div_go = 1'b1;
               dv_hi  = wide[127:64];
               dv_lo  = wide[63:0];
               dv_c   = width_in;
               dv_ret = ST_TAU_FIN;
            end
         end
         ST_TAU_FIN: begin
            tau_in   = div_q_ff[30:0];
            state_in = ST_CON_A;
         end
         ST_CON_A: begin
            mul_x    = mag_of(b_w);
            mul_y    = rpce_pkg::MUL_W'(tau_ff);
            w2_in    = W_ONE + a_w + b_w;
            state_in = ST_CON_B;
         end
         ST_CON_B: begin
            con1_in  = signed_of(b_ff[31], prod_hi) <<< 1;
            mul_x    = mag_of(a_w);
            mul_y    = rpce_pkg::MUL_W'(TAU_ONE - tau_ff);
            state_in = ST_CON_C;
         end
         ST_CON_C: begin
            con2_in  = W_ONE + b_w + signed_of(a_ff[31], prod_hi);
            state_in = ST_ETA_SEL;
         end
         ST_ETA_SEL: begin
            if (con1_ff == '0) begin
               // tiny linear term: eta = tau / con2
               eta_go  = 1'b1;
               eta_num = 32'(tau_ff);
               eta_den = con2_ff;
            end else begin
               mul_x    = mag_of(con2_ff);
               mul_y    = mag_of(con2_ff);
               state_in = ST_SQ_B;
            end
         end
         ST_SQ_B: begin
            d_in     = prod_ff[65:2];
            mul_x    = mag_of(con1_ff);
            mul_y    = rpce_pkg::MUL_W'(tau_ff);
            state_in = ST_SQ_C;
         end
         ST_SQ_C: begin
            s = prod_ff[64:1];
            if (!con1_ff[rpce_pkg::WRK_W-1]) begin
               d_in = (d_ff >= s) ? d_ff - s : '0;
            end else begin
               d_in = d_ff + s;
            end
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            // one root digit per cycle
            rem_n = {rem_ff, d_ff[63:62]};
            trial = {2'b00, root_ff, 2'b01};
            if (rem_n >= trial) begin
               rem_in  = 34'(rem_n - trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_n[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            d_in   = {d_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = ST_ROOT_DEN;
            end
         end
         ST_ROOT_DEN: begin
            root2 = $signed({3'b000, root_ff, 1'b0});
            den   = con2_ff[rpce_pkg::WRK_W-1] ? con2_ff - root2 : con2_ff + root2;
            eta_go  = 1'b1;
            eta_num = {tau_ff, 1'b0};
            eta_den = den;
         end
         ST_ETA_FIN: begin
            eta_in   = (div_q_ff > 64'(TAU_ONE)) ? TAU_ONE : div_q_ff[30:0];
            state_in = ST_EV_A;
         end
         ST_EV_A: begin
            mul_x    = mag_of(b_w);
            mul_y    = rpce_pkg::MUL_W'(eta_ff);
            state_in = ST_EV_B;
         end
         ST_EV_B: begin
            u_in     = a_w + signed_of(b_ff[31], prod_hi);
            mul_x    = rpce_pkg::MUL_W'(eta_ff);
            mul_y    = rpce_pkg::MUL_W'(eta_ff);
            state_in = ST_EV_C;
         end
         ST_EV_C: begin
            ee_in    = prod_ff[60:30];
            mul_x    = mag_of(u_ff);
            mul_y    = rpce_pkg::MUL_W'(eta_ff);
            state_in = ST_EV_D;
         end
         ST_EV_D: begin
            v_in     = W_ONE + signed_of(u_ff[rpce_pkg::WRK_W-1], prod_hi);
            mul_x    = mag_of(b_w);
            mul_y    = rpce_pkg::MUL_W'(ee_ff);
            state_in = ST_EV_E;
         end
         ST_EV_E: begin
            w1_in    = W_ONE - signed_of(b_ff[31], prod_hi);
            mul_x    = mag_of(v_ff);
            mul_y    = mag_of(v_ff);
            state_in = ST_EV_F;
         end
         ST_EV_F: begin
            v2_in    = prod_hi;
            mul_x    = mag_of(w1_ff);
            mul_y    = mag_of(w2_ff);
            state_in = ST_EV_G;
         end
         ST_EV_G: begin
            dn_in    = prod_hi;
            mul_x    = rpce_pkg::MUL_W'(eta_ff);
            mul_y    = rpce_pkg::MUL_W'(mass_ff);
            state_in = ST_EV_H;
         end
         ST_EV_H: begin
            cdf_sum  = 34'(cum_ff) + 34'(prod_ff[62:30]);
            cdf_in   = (cdf_sum > 34'(rpce_pkg::CDF_ONE)) ? rpce_pkg::CDF_ONE
                                                          : cdf_sum[32:0];
            mul_x    = rpce_pkg::MUL_W'(mass_ff);
            mul_y    = rpce_pkg::MUL_W'(v2_ff[31:0]);
            state_in = ST_EV_I;
         end
         ST_EV_I: begin
            plo_in   = prod_ff[63:0];
            mul_x    = rpce_pkg::MUL_W'(mass_ff);
            mul_y    = rpce_pkg::MUL_W'(v2_ff[35:32]);
            state_in = ST_EV_J;
         end
         ST_EV_J: begin
            wide   = 128'(plo_ff) + (128'(prod_ff) << 32);
            dn_neg = (w1_ff[rpce_pkg::WRK_W-1] != w2_ff[rpce_pkg::WRK_W-1]) && (dn_ff != '0);
            if (dn_neg) begin
               out_go  = 1'b1;
               out_cdf = cdf_ff;
            end else if (dn_ff == '0) begin
               out_go  = 1'b1;
               out_pdf = ((mass_ff == '0) || (v2_ff == '0)) ? '0 : '1;
               out_cdf = cdf_ff;
            end else begin
               div_go = 1'b1;
               dv_hi  = wide[127:64];
               dv_lo  = wide[63:0];
               dv_c   = 64'(dn_ff);
               dv_ret = ST_PDF_T;
            end
         end
         ST_PDF_T: begin
            wide   = 128'(div_q_ff) << rpce_pkg::X_FRAC_BITS;
            div_go = 1'b1;
            dv_hi  = wide[127:64];
            dv_lo  = wide[63:0];
            dv_c   = width_ff;
            dv_ret = ST_PDF_FIN;
         end
         ST_PDF_FIN: begin
            out_go  = 1'b1;
            out_pdf = div_q_ff;
            out_cdf = cdf_ff;
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            sh   = {div_hi_ff[62:0], div_lo_ff[63]};
            qbit = div_hi_ff[63] || (sh >= div_c_ff);
            div_hi_in = qbit ? sh - div_c_ff : sh;
            div_lo_in = {div_lo_ff[62:0], 1'b0};
            div_q_in  = {div_q_ff[62:0], qbit};
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // eta = num / den clamped to [0, 1]; negative denominator gives 0
      if (eta_go) begin
         if (eta_den[rpce_pkg::WRK_W-1]) begin
            eta_in   = '0;
            state_in = ST_EV_A;
         end else if (eta_den == '0) begin
            eta_in   = (eta_num != '0) ? TAU_ONE : '0;
            state_in = ST_EV_A;
         end else begin
            div_go = 1'b1;
            dv_hi  = '0;
            dv_lo  = 64'(eta_num) << rpce_pkg::W_FRAC;
            dv_c   = 64'(eta_den);
            dv_ret = ST_ETA_FIN;
         end
      end

      // divider launch; a quotient that overflows saturates at once
      if (div_go) begin
         div_hi_in = dv_hi;
         div_lo_in = dv_lo;
         div_c_in  = dv_c;
         ret_in    = dv_ret;
         cnt_in    = '0;
         if (dv_hi >= dv_c) begin
            div_q_in = '1;
            state_in = dv_ret;
         end else begin
            div_q_in = '0;
            state_in = ST_DIV;
         end
      end

      if (out_go) begin
         rsp_valid_in      = 1'b1;
         rsp_in.pdf_value  = out_pdf;
         rsp_in.cdf_value  = out_cdf;
         state_in          = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pts_ff       <= rpce_pkg::CSR_W'(2);
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pts_ff       <= pts_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;      hi_ff    <= hi_in;      mid_ff   <= mid_in;
      rsp_ff    <= rsp_in;
      x_ff      <= x_in;       g0_ff    <= g0_in;
      a_ff      <= a_in;       b_ff     <= b_in;
      cum_ff    <= cum_in;     mass_ff  <= mass_in;    width_ff <= width_in;
      tau_ff    <= tau_in;     eta_ff   <= eta_in;     ee_ff    <= ee_in;
      con1_ff   <= con1_in;    con2_ff  <= con2_in;
      u_ff      <= u_in;       v_ff     <= v_in;
      w1_ff     <= w1_in;      w2_ff    <= w2_in;
      v2_ff     <= v2_in;      dn_ff    <= dn_in;      plo_ff   <= plo_in;
      cdf_ff    <= cdf_in;     d_ff     <= d_in;
      rem_ff    <= rem_in;     root_ff  <= root_in;
      div_hi_ff <= div_hi_in;  div_lo_ff <= div_lo_in;
      div_c_ff  <= div_c_in;   div_q_ff  <= div_q_in;
      prod_ff   <= prod_in;
   end

endmodule

// File: hw/rtl/rpce_checker.sv
module rpce_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input rpce_pkg::req_type          req_item,
   input logic                       rsp_valid,
   input rpce_pkg::rsp_type          rsp_item
);

   // cdf never passes one
   a_cdf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.cdf_value <= rpce_pkg::CDF_ONE))
      else $error("cdf above one");

   // a load request completes in its accept cycle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.func == rpce_pkg::FUNC_LOAD)) |=> !busy)
      else $error("load request raised busy");

   // a query request goes busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.func == rpce_pkg::FUNC_QUERY)) |=> busy)
      else $error("query request not taken");

   // a result only closes a busy stretch
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result without a query");

   // results never come back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind rita_pdf_cdf_evaluator_core rpce_checker u_rpce_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// File: sim/tb_top.sv
module tb_top;

   localparam longint ONE_W30 = 64'sd1 << 30;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   rpce_pkg::req_type req_item = '0;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [rpce_pkg::CSR_W-1:0] csr_data = '0;
   logic    rsp_valid;
   rpce_pkg::rsp_type rsp_item;

   rita_pdf_cdf_evaluator_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the table and the point count register
   longint      grid_pt [rpce_pkg::MAX_POINTS];
   longint      coef_a_tab [rpce_pkg::MAX_POINTS];
   longint      coef_b_tab [rpce_pkg::MAX_POINTS];
   logic [63:0] cum_tab [rpce_pkg::MAX_POINTS];
   logic [63:0] mass_tab [rpce_pkg::MAX_POINTS];
   logic [9:0]  points_reg = 10'd2;

   rpce_pkg::rsp_type pending_answers[$];
   int      mismatch_count = 0;
   int      requests_sent = 0;
   bit      quiet = 1'b0;   // no idling in the closing stretch

   // ---------------------------------------------------------------------
   // fixed point helpers (W30 working values, magnitudes truncate)
   // ---------------------------------------------------------------------
   function automatic logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // floor(a*b / 2^sh), saturating
   function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      logic [127:0] q;
      p = {64'b0, a} * {64'b0, b};
      if ((p >> (64 + sh)) != 0) return '1;
      q = p >> sh;
      return q[63:0];
   endfunction

   function automatic longint smul_shr(longint a, longint b, int sh);
      logic [63:0] m;
      m = mul_shr(mag(a), mag(b), sh);
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   // floor(a*b / c), c nonzero, saturating
   function automatic logic [63:0] scale_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [127:0] p;
      logic [127:0] q;
      p = {64'b0, a} * {64'b0, b};
      if (p[127:64] >= c) return '1;
      q = p / {64'b0, c};
      return q[63:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] d);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > d) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (d >= res + bitv) begin
            d   = d - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // eta = num/den clamped to [0,1]; negative denominator gives 0
   function automatic longint eta_quot(longint num, longint den);
      logic [63:0] q;
      if (den < 0) return 0;
      if (den == 0) return num > 0 ? ONE_W30 : 0;
      q = scale_div(64'(num), 64'(ONE_W30), 64'(den));
      return q > 64'(ONE_W30) ? ONE_W30 : longint'(q);
   endfunction

   // pdf and cdf of the rational interval that holds x
   function automatic rpce_pkg::rsp_type eval_density(longint x);
      rpce_pkg::rsp_type r;
      int          np, lo, hi, mid, i;
      longint      a, b, tau, con1, con2, eta, u, v, w1, w2, root;
      logic [63:0] width, num, mass, v2, dn, sq, s, d, t, cdf;
      bit          dn_neg;
      np = points_reg < 2 ? 2 : int'(points_reg);
      if (np > rpce_pkg::MAX_POINTS) np = rpce_pkg::MAX_POINTS;
      if (x > grid_pt[np-1]) begin
         r.pdf_value = 0; r.cdf_value = rpce_pkg::CDF_ONE; return r;
      end
      if (x < grid_pt[0]) begin
         r.pdf_value = 0; r.cdf_value = 0; return r;
      end
      lo = 1;
      hi = np;
      do begin
         mid = (lo + hi) / 2;
         if (x > grid_pt[mid-1]) lo = mid;
         else hi = mid;
      end while (hi - lo > 1);
      i = lo - 1;
      mass = mass_tab[i];
      // empty or reversed interval
      if (grid_pt[i+1] <= grid_pt[i]) begin
         r.pdf_value = 0; r.cdf_value = 33'(cum_tab[i]); return r;
      end
      width = 64'(grid_pt[i+1]) - 64'(grid_pt[i]);
      if (x <= grid_pt[i]) begin
         tau = 0;
      end else begin
         num = 64'(x) - 64'(grid_pt[i]);
         tau = num >= width ? ONE_W30 : longint'(scale_div(num, 64'(ONE_W30), width));
      end
      a = coef_a_tab[i];
      b = coef_b_tab[i];
      con1 = 2 * smul_shr(b, tau, 30);
      con2 = ONE_W30 + b + smul_shr(a, ONE_W30 - tau, 30);
      if (con1 == 0) begin
         eta = con2 < 0 ? 0 : eta_quot(tau, con2);
      end else begin
         sq = mul_shr(mag(con2), mag(con2), 2);
         s  = mul_shr(mag(con1), 64'(tau), 1);
         if (con1 >= 0) d = sq >= s ? sq - s : 64'd0;
         else d = sq + s;
         root = longint'(int_sqrt(d) << 1);
         eta = eta_quot(2 * tau, con2 >= 0 ? con2 + root : con2 - root);
      end
      u  = a + smul_shr(b, eta, 30);
      v  = ONE_W30 + smul_shr(u, eta, 30);
      v2 = mul_shr(mag(v), mag(v), 30);
      w1 = ONE_W30 - smul_shr(b, smul_shr(eta, eta, 30), 30);
      w2 = ONE_W30 + a + b;
      dn = mul_shr(mag(w1), mag(w2), 30);
      dn_neg = ((w1 < 0) != (w2 < 0)) && dn != 0;
      if (dn_neg) begin
         r.pdf_value = 0;
      end else if (dn == 0) begin
         r.pdf_value = (mass == 0 || v2 == 0) ? 64'd0 : '1;
      end else begin
         t = scale_div(mass, v2, dn);
         r.pdf_value = scale_div(t, 64'd1 << rpce_pkg::X_FRAC_BITS, width);
      end
      cdf = cum_tab[i] + mul_shr(64'(eta), mass, 30);
      if (cdf > 64'(rpce_pkg::CDF_ONE)) cdf = 64'(rpce_pkg::CDF_ONE);
      r.cdf_value = cdf[32:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // drivers: change at falling edge, sample at rising edge
   // ---------------------------------------------------------------------
   task automatic rest(int lo_n, int hi_n);
      start <= 1'b0;
      repeat ($urandom_range(lo_n, hi_n)) @(negedge clock);
   endtask

   // send one request; returns at a falling edge once taken, start high unless rested
   task automatic send_request(rpce_pkg::req_type r);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      requests_sent++;
      if (r.func == rpce_pkg::FUNC_LOAD) begin
         grid_pt[r.entry_index]    = r.x_value;
         coef_a_tab[r.entry_index] = r.coef_a;
         coef_b_tab[r.entry_index] = r.coef_b;
         cum_tab[r.entry_index]    = 64'(r.cum_prob);
         mass_tab[r.entry_index]   = 64'(r.interval_prob);
      end else begin
         pending_answers.push_back(eval_density(r.x_value));
      end
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) rest(1, 16);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_answers.size() != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_points(logic [9:0] n);
      wait_drained();
      if (!quiet && $urandom_range(0, 1)) repeat ($urandom_range(1, 16)) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= n;
      do @(posedge clock); while (!csr_ready);
      points_reg = n;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic rpce_pkg::req_type make_load(int idx, longint x, longint a, longint b,
                                                   logic [31:0] cum, logic [31:0] mass);
      rpce_pkg::req_type r;
      r.func = rpce_pkg::FUNC_LOAD; r.entry_index = idx[8:0]; r.x_value = x;
      r.coef_a = a[31:0]; r.coef_b = b[31:0];
      r.cum_prob = cum; r.interval_prob = mass;
      return r;
   endfunction

   function automatic rpce_pkg::req_type make_query(longint x);
      rpce_pkg::req_type r;
      logic [223:0]      junk;
      junk = {$urandom, rand64(), rand64(), rand64()};   // junk in unused fields
      r = rpce_pkg::req_type'(junk[$bits(rpce_pkg::req_type)-1:0]);
      r.func = rpce_pkg::FUNC_QUERY;
      r.x_value = x;
      return r;
   endfunction

   task automatic load_point(int idx, longint x, longint a, longint b,
                             logic [31:0] cum, logic [31:0] mass);
      send_request(make_load(idx, x, a, b, cum, mass));
   endtask

   task automatic query(longint x);
      send_request(make_query(x));
   endtask

   // random interval coefficients: mostly well behaved, some extreme
   function automatic longint rand_coef();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return longint'($signed($urandom));
         default: return longint'($signed($urandom_range(0, 1 << 30))) - (1 << 29);
      endcase
   endfunction

   // write entries 0..n-1 as an ascending grid, optionally with some bad steps
   task automatic load_grid(int n, bit messy);
      longint x, stepv;
      logic [31:0] cum;
      x   = longint'($signed(rand64())) >>> $urandom_range(4, 40);
      cum = 0;
      for (int k = 0; k < n; k++) begin
         logic [31:0] mass;
         mass = $urandom_range(0, 3) == 0 ? $urandom : $urandom >> $urandom_range(4, 12);
         load_point(k, x, rand_coef(), rand_coef(),
                    $urandom_range(0, 4) == 0 ? $urandom : cum, mass);
         cum   = cum + mass;
         stepv = longint'(rand64() >> $urandom_range(24, 60)) + 1;
         if (messy && $urandom_range(0, 9) == 0) stepv = -longint'($urandom_range(0, 3));
         x = x + stepv;
      end
   endtask

   // query near the live grid: inside intervals, on points, or outside; sometimes anywhere
   function automatic longint pick_x();
      int np, k;
      longint lo_x, hi_x, span;
      np = points_reg < 2 ? 2 : int'(points_reg);
      if (np > rpce_pkg::MAX_POINTS) np = rpce_pkg::MAX_POINTS;
      k = $urandom_range(0, np - 2);
      lo_x = grid_pt[k];
      hi_x = grid_pt[k+1];
      case ($urandom_range(0, 9))
         0: return longint'(rand64());
         1: return grid_pt[$urandom_range(0, np - 1)];
         2: return grid_pt[0] - longint'($urandom_range(1, 1000));
         3: return grid_pt[np-1] + longint'($urandom_range(1, 1000));
         default: begin
            span = hi_x > lo_x ? hi_x - lo_x : 1;
            return lo_x + longint'(rand64() % 64'(span));
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result pdf=%h cdf=%h", rsp_item.pdf_value,
                        rsp_item.cdf_value);
         end else begin
            rpce_pkg::rsp_type exp_r;
            exp_r = pending_answers.pop_front();
            if (rsp_item.pdf_value !== exp_r.pdf_value ||
                rsp_item.cdf_value !== exp_r.cdf_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: pdf exp %h got %h, cdf exp %h got %h",
                           exp_r.pdf_value, rsp_item.pdf_value,
                           exp_r.cdf_value, rsp_item.cdf_value);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   localparam longint X_MIN = 64'sh8000_0000_0000_0000;
   localparam longint X_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam longint C_MIN = -(64'sd1 << 31);
   localparam longint C_MAX = (64'sd1 << 31) - 1;

   // edges of the grid, extreme coefficients, empty interval, saturation
   task automatic test_directed();
      load_point(0, X_MIN, 0, 0, 0, 32'h4000_0000);           // linear term zero
      load_point(1, 0, C_MIN, C_MAX, 32'hffff_ffff, 32'hffff_ffff);
      load_point(2, 64'sh1_0000_0000, C_MAX, C_MIN, 32'h8000_0000, 32'h1000);
      load_point(3, X_MAX, C_MIN, C_MIN, 0, 0);
      write_points(10'd4);
      query(X_MIN);                 // on the first point
      query(X_MAX);                 // on the last point
      query(-1);
      query(64'sh8000_0000);
      query(64'sh1_0000_0000);
      query(64'sh7000_0000_0000_0000);
      load_point(0, -(64'sd1 << 40), C_MAX, C_MAX, 32'h1234_5678, 32'hffff_ffff);
      query(X_MIN);                 // below the grid
      query(-(64'sd1 << 39));
      load_point(1, 64'sh2_0000_0000, 0, C_MIN, 32'h55, 32'h77); // reversed interval
      query(64'sh1_8000_0000);
      write_points(10'd3);
      query(X_MAX);                 // above the grid
      query(64'sh1_8000_0000);
   endtask

   // register extremes, including out of range values
   task automatic test_points_extremes();
      write_points(10'd2);
      load_grid(rpce_pkg::MAX_POINTS, 1'b0);
      write_points(10'd1023);
      repeat (6) query(pick_x());
      write_points(10'd512);
      repeat (6) query(pick_x());
      write_points(10'd0);
      repeat (4) query(pick_x());
      write_points(10'd1);
      repeat (4) query(pick_x());
   endtask

   task automatic test_random(int target);
      while (requests_sent < target) begin
         int np, nq;
         if (requests_sent > target * 85 / 100) quiet = 1'b1;
         case ($urandom_range(0, 7))
            0:       np = 2;
            1:       np = 3;
            2:       np = $urandom_range(0, 1) ? rpce_pkg::MAX_POINTS : 1023;
            default: np = $urandom_range(4, 24);
         endcase
         write_points(10'(np));
         if (np < rpce_pkg::MAX_POINTS) load_grid(np, $urandom_range(0, 2) == 0);
         nq = $urandom_range(8, 40);
         for (int k = 0; k < nq; k++) begin
            if ($urandom_range(0, 15) == 0)
               load_point($urandom_range(0, rpce_pkg::MAX_POINTS - 1), pick_x(),
                          rand_coef(), rand_coef(), $urandom, $urandom);
            else
               query(pick_x());
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_points_extremes();
      test_random(950);
      wait_drained();
      repeat (400) @(negedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
